[design/open_addressing_hash_map_unit_defines.svh]
// Assertion helpers for the asserting file.
`ifndef OPEN_ADDRESSING_HASH_MAP_UNIT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_MAP_UNIT_DEFINES_SVH

// Check on every edge outside reset.
`define OAHM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Check on every edge, reset included.
`define OAHM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[design/oahm_pkg.sv]
`timescale 1ns / 1ps
package oahm_pkg;

  localparam int TABLE_SIZE_DEF = 1021;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [63:0] SIP_K0 = 64'h62d76395429756a9;
  localparam logic [63:0] SIP_K1 = 64'he26534637479058c;

  localparam logic [6:0] LOAD_RESET = 7'd70;
  localparam int         PERCENT    = 100;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  localparam logic [1:0] TAG_EMPTY   = 2'd0;
  localparam logic [1:0] TAG_USED    = 2'd1;
  localparam logic [1:0] TAG_DELETED = 2'd2;

  localparam int ENTRY_W = 10;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        value_out;
    logic [ENTRY_W-1:0] entry_total;
  } res_t;

  typedef logic [3:0][63:0] sipv_t;

endpackage

[design/open_addressing_hash_map_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake        Beat
// in_      input      in_push/in_full  command, key, value
// out_     output     out_pop/out_empty status, value_out, entry_total
// cfg_     input      cfg_wr_en        load_limit_percent (7 bits)
//
// Front: each command is hashed in rounds over M messages (M = 2 for keys
// of eight bytes, else 1), then reduced modulo TABLE_SIZE, then pushed
// into the command queue; it takes no new beat until that push is done.
// Back: each slot probe is a registered memory read, then a compare; a
// clear sweeps every slot of the tag memory.
// Reset (rst_n low, synchronous) starts a clearing pass over the tag
// memory; commands queue during it but are not carried out.
// A waiting result stalls the back; the front keeps hashing into the
// two-entry queue until it fills, and raises in_full while it is busy.
`include "open_addressing_hash_map_unit_defines.svh"
module open_addressing_hash_map_unit #(
  parameter int TABLE_SIZE = oahm_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = oahm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = oahm_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [9:0]  out_entry_total,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  // stored value width: the value port carries at most 32 bits
  localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int QW    = 2 + KEY_BITS + VW + IDX_W;

  logic [6:0]     load_r;
  logic           q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]  q_wdata, q_rdata;
  logic           res_valid;
  oahm_pkg::res_t res;

  // hold the load limit; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= oahm_pkg::LOAD_RESET;
    end else if (cfg_wr_en) begin
      load_r <= cfg_wr_data;
    end
  end

  oahm_front #(
    .TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .IDX_W(IDX_W), .VW(VW), .QW(QW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_command(in_command), .in_key(in_key), .in_value(in_value),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  // decouple hashing from probing
  oahm_fifo #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  oahm_back #(
    .TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .IDX_W(IDX_W), .VW(VW), .QW(QW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .load_limit(load_r),
    .res_valid(res_valid), .res(res), .res_pop(out_pop)
  );

  assign out_empty       = !res_valid;
  assign out_status      = res.status;
  assign out_value_out   = res.value_out;
  assign out_entry_total = res.entry_total;

  // a clear leaves the table empty
  `OAHM_ASSERT(a_clear_zero, clk, rst_n, (!out_empty && out_status == oahm_pkg::ST_CLEARED) |-> (out_entry_total == 10'd0), "clear result with entries")
  // only a lookup hit carries a value
  `OAHM_ASSERT(a_value_hit, clk, rst_n, (!out_empty && out_status != oahm_pkg::ST_FOUND) |-> (out_value_out == 32'd0), "value on non-hit result")
  // the back never pulls a command while a result is still held
  `OAHM_ASSERT(a_pop_free, clk, rst_n, q_pop |-> (out_empty && !q_empty), "queue pop with result held")
  // a reset leaves no result held
  `OAHM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty, "result after reset")

endmodule

[design/oahm_fifo.sv]
`timescale 1ns / 1ps
module oahm_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = !wp_r;
    end
    if (pop && !empty) begin
      rp_nxt = !rp_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

[design/oahm_front.sv]
`timescale 1ns / 1ps
module oahm_front #(
  parameter int TABLE_SIZE = oahm_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = oahm_pkg::KEY_BITS_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE),
  parameter int VW         = 32,
  parameter int QW         = 2 + KEY_BITS + VW + IDX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_command,
  input  logic [63:0]   in_key,
  input  logic [31:0]   in_value,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int MSGS      = (KEY_BYTES >= 8) ? 2 : 1;
  localparam logic [2:0] ABS_END = 3'(2 * MSGS);
  localparam logic [2:0] LAST_R  = 3'(2 * MSGS + 3);
  localparam logic [63:0] LASTW  = 64'(KEY_BYTES) << 56;
  localparam logic [IDX_W:0] NMOD = (IDX_W + 1)'(TABLE_SIZE);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]          st_r, st_nxt;
  logic [2:0]          rc_r, rc_nxt;
  logic [3:0]          dig_r, dig_nxt;
  oahm_pkg::sipv_t     v_r, v_nxt;
  logic [63:0]         hash_r, hash_nxt;
  logic [IDX_W-1:0]    rem_r, rem_nxt;
  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VW-1:0]       val_r;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic oahm_pkg::sipv_t sip_round(input oahm_pkg::sipv_t v);
    oahm_pkg::sipv_t w;
    w = v;
    w[0] = w[0] + w[1]; w[1] = rotl(w[1], 13); w[1] = w[1] ^ w[0]; w[0] = rotl(w[0], 32);
    w[2] = w[2] + w[3]; w[3] = rotl(w[3], 16); w[3] = w[3] ^ w[2];
    w[0] = w[0] + w[3]; w[3] = rotl(w[3], 21); w[3] = w[3] ^ w[0];
    w[2] = w[2] + w[1]; w[1] = rotl(w[1], 17); w[1] = w[1] ^ w[2]; w[2] = rotl(w[2], 32);
    return w;
  endfunction

  logic [63:0]     key64, msg;
  oahm_pkg::sipv_t vin, vout;
  logic [IDX_W:0]  tw;
  logic [IDX_W-1:0] rr;

  assign key64 = 64'(key_r);

  always_comb begin
    if (MSGS == 2 && rc_r < 3'd2) begin
      msg = key64;
    end else if (MSGS == 2) begin
      msg = LASTW;
    end else begin
      msg = LASTW | key64;
    end
    vin = v_r;
    if (rc_r < ABS_END && !rc_r[0]) begin
      vin[3] = vin[3] ^ msg;
    end
    vout = sip_round(vin);
    if (rc_r < ABS_END && rc_r[0]) begin
      vout[0] = vout[0] ^ msg;
    end
    if (rc_r == ABS_END - 3'd1) begin
      vout[2] = vout[2] ^ 64'hFF;
    end
  end

  // four remainder digits per cycle, top nibble first
  always_comb begin
    rr = rem_r;
    tw = '0;
    for (int j = 0; j < 4; j++) begin
      tw = {rr, hash_r[63 - j]};
      if (tw >= NMOD) begin
        tw = tw - NMOD;
      end
      rr = tw[IDX_W-1:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    rc_nxt   = rc_r;
    dig_nxt  = dig_r;
    v_nxt    = v_r;
    hash_nxt = hash_r;
    rem_nxt  = rem_r;
    case (st_r)
      F_IDLE: begin
        if (in_push) begin
          v_nxt[0] = oahm_pkg::SIP_K0 ^ 64'h736f6d6570736575;
          v_nxt[1] = oahm_pkg::SIP_K1 ^ 64'h646f72616e646f6d;
          v_nxt[2] = oahm_pkg::SIP_K0 ^ 64'h6c7967656e657261;
          v_nxt[3] = oahm_pkg::SIP_K1 ^ 64'h7465646279746573;
          rc_nxt   = 3'd0;
          st_nxt   = F_HASH;
        end
      end
      F_HASH: begin
        v_nxt  = vout;
        rc_nxt = rc_r + 3'd1;
        if (rc_r == LAST_R) begin
          hash_nxt = vout[0] ^ vout[1] ^ vout[2] ^ vout[3];
          rem_nxt  = '0;
          dig_nxt  = 4'd0;
          st_nxt   = F_MOD;
        end
      end
      F_MOD: begin
        rem_nxt  = rr;
        hash_nxt = hash_r << 4;
        dig_nxt  = dig_r + 4'd1;
        if (dig_r == 4'd15) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rc_r   <= rc_nxt;
    dig_r  <= dig_nxt;
    v_r    <= v_nxt;
    hash_r <= hash_nxt;
    rem_r  <= rem_nxt;
    if (st_r == F_IDLE && in_push) begin
      cmd_r <= in_command;
      key_r <= in_key[KEY_BITS-1:0];
      val_r <= in_value[VW-1:0];
    end
  end

  assign in_full = st_r != F_IDLE;
  assign q_push  = st_r == F_PUSH && !q_full;
  assign q_data  = {cmd_r, key_r, val_r, rem_r};

endmodule

[design/oahm_back.sv]
`timescale 1ns / 1ps
module oahm_back #(
  parameter int TABLE_SIZE = oahm_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = oahm_pkg::KEY_BITS_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE),
  parameter int VW         = 32,
  parameter int QW         = 2 + KEY_BITS + VW + IDX_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [QW-1:0]  q_data,
  input  logic [6:0]     load_limit,
  output logic           res_valid,
  output oahm_pkg::res_t res,
  input  logic           res_pop
);

  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int LD_W  = $clog2(128 * TABLE_SIZE + 1);
  localparam logic [IDX_W:0] NMOD = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  localparam logic [1:0] B_SWEEP = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_READ  = 2'd2;
  localparam logic [1:0] B_CHECK = 2'd3;

  logic [1:0]          tag_mem [TABLE_SIZE];
  logic [KEY_BITS-1:0] key_mem [TABLE_SIZE];
  logic [VW-1:0]       val_mem [TABLE_SIZE];

  logic [1:0]          rd_tag;
  logic [KEY_BITS-1:0] rd_key;
  logic [VW-1:0]       rd_val;

  logic [1:0]          st_r, st_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    att_r, att_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                clr_r, clr_nxt;
  logic                rv_r, rv_nxt;
  oahm_pkg::res_t      res_r, res_nxt;
  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VW-1:0]       val_r;

  logic                tag_we, key_we, val_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [1:0]          tag_wd;

  logic [1:0]          q_cmd;
  logic [KEY_BITS-1:0] q_key;
  logic [VW-1:0]       q_val;
  logic [IDX_W-1:0]    q_home;

  logic [IDX_W:0]      step;
  logic [IDX_W-1:0]    next_idx;
  logic [LD_W-1:0]     ld_lhs, ld_rhs;
  logic                over;

  assign {q_cmd, q_key, q_val, q_home} = q_data;

  assign step     = (IDX_W + 1)'(idx_r) + (IDX_W + 1)'(att_r) + (IDX_W + 1)'(1);
  assign next_idx = (step >= NMOD) ? IDX_W'(step - NMOD) : step[IDX_W-1:0];
  assign ld_lhs   = LD_W'(cnt_r) * LD_W'(oahm_pkg::PERCENT);
  assign ld_rhs   = (LD_W'(load_limit) + LD_W'(1)) * LD_W'(TABLE_SIZE);
  assign over     = ld_lhs >= ld_rhs;

  assign q_pop = st_r == B_IDLE && !q_empty && !rv_r;

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    att_nxt = att_r;
    cnt_nxt = cnt_r;
    clr_nxt = clr_r;
    rv_nxt  = rv_r;
    res_nxt = res_r;
    tag_we  = 1'b0;
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = idx_r;
    tag_wd  = oahm_pkg::TAG_EMPTY;
    if (res_pop && rv_r) begin
      rv_nxt = 1'b0;
    end
    case (st_r)
      B_SWEEP: begin
        tag_we  = 1'b1;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          st_nxt  = B_IDLE;
          clr_nxt = 1'b0;
          if (clr_r) begin
            rv_nxt  = 1'b1;
            res_nxt = '{oahm_pkg::ST_CLEARED, 32'd0, '0};
          end
        end
      end
      B_IDLE: begin
        if (q_pop) begin
          att_nxt = '0;
          if (q_cmd == oahm_pkg::CMD_CLEAR) begin
            cnt_nxt = '0;
            idx_nxt = '0;
            clr_nxt = 1'b1;
            st_nxt  = B_SWEEP;
          end else begin
            idx_nxt = q_home;
            st_nxt  = B_READ;
          end
        end
      end
      B_READ: begin
        st_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (rd_tag == oahm_pkg::TAG_USED && rd_key == key_r) begin
          st_nxt = B_IDLE;
          rv_nxt = 1'b1;
          res_nxt.value_out = 32'd0;
          case (cmd_r)
            oahm_pkg::CMD_INSERT: begin
              val_we = 1'b1;
              res_nxt.status = oahm_pkg::ST_UPDATED;
            end
            oahm_pkg::CMD_LOOKUP: begin
              res_nxt.value_out = 32'(rd_val);
              res_nxt.status    = oahm_pkg::ST_FOUND;
            end
            default: begin
              tag_we = 1'b1;
              tag_wd = oahm_pkg::TAG_DELETED;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
              res_nxt.status = oahm_pkg::ST_REMOVED;
            end
          endcase
          res_nxt.entry_total = oahm_pkg::ENTRY_W'(cnt_nxt);
        end else if (rd_tag == oahm_pkg::TAG_EMPTY || att_r + CNT_W'(1) == CNT_W'(TABLE_SIZE)) begin
          // miss: free slot only when probing stopped at an empty one
          st_nxt = B_IDLE;
          rv_nxt = 1'b1;
          res_nxt.value_out = 32'd0;
          res_nxt.status    = oahm_pkg::ST_NOT_FOUND;
          if (cmd_r == oahm_pkg::CMD_INSERT) begin
            if (over || rd_tag != oahm_pkg::TAG_EMPTY) begin
              res_nxt.status = oahm_pkg::ST_FULL;
            end else begin
              tag_we  = 1'b1;
              key_we  = 1'b1;
              val_we  = 1'b1;
              tag_wd  = oahm_pkg::TAG_USED;
              cnt_nxt = cnt_r + CNT_W'(1);
              res_nxt.status = oahm_pkg::ST_INSERTED;
            end
          end
          res_nxt.entry_total = oahm_pkg::ENTRY_W'(cnt_nxt);
        end else begin
          att_nxt = att_r + CNT_W'(1);
          idx_nxt = next_idx;
          st_nxt  = B_READ;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_SWEEP;
      idx_r <= '0;
      cnt_r <= '0;
      clr_r <= 1'b0;
      rv_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      rv_r  <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    att_r <= att_nxt;
    res_r <= res_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
      key_r <= q_key;
      val_r <= q_val;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= tag_wd;
    end
    rd_tag <= tag_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    rd_key <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_r;
    end
    rd_val <= val_mem[idx_r];
  end

  assign res_valid = rv_r;
  assign res       = res_r;

endmodule
